@@ hw/rtl/ray_triangle_intersect_top_defines.svh @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection: assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_TOP_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_DEFINES_SVH

// Same-cycle implication.
`define RTI_ASSERT_IMP(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication.
`define RTI_ASSERT_NXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

@@ hw/rtl/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Widths, beat types, register indexes and vector helpers.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int CW    = COORD_WIDTH;
	localparam int EW    = CW + 1;          // edge and offset vectors
	localparam int PW    = 2 * EW + 1;      // cross product terms
	localparam int MW    = EW + PW;         // dot product partial products
	localparam int DW    = MW + 2;          // dot product sums
	localparam int NW    = DW + 1;          // sums after sign fix
	localparam int MPW   = 16;              // tolerance register width
	localparam int MDW   = NW + MPW + 1;    // determinant times tolerance
	localparam int XW    = MDW + 2;         // compare width
	localparam int FRAC  = 16;              // output fraction bits
	localparam int TOL_SHIFT = 8;
	localparam int RW    = NW + FRAC;       // dividend width
	localparam int QBITS = 32;              // quotient bits
	localparam int QW    = NW + QBITS;      // shifted divisor width
	localparam int VTX_W = 48;
	localparam int IDX_W = 8;

	typedef enum logic [IDX_W-1:0] {
		REG_VERTEX_A  = 8'd0,
		REG_VERTEX_B  = 8'd1,
		REG_VERTEX_C  = 8'd2,
		REG_TOLERANCE = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] distance;
	} result_t;

	typedef struct packed {
		logic signed [EW-1:0] x;
		logic signed [EW-1:0] y;
		logic signed [EW-1:0] z;
	} evec_t;

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [PW-1:0] z;
	} pvec_t;

	typedef struct packed {
		logic signed [MW-1:0] x;
		logic signed [MW-1:0] y;
		logic signed [MW-1:0] z;
	} mvec_t;

	typedef struct packed {
		evec_t a;
		evec_t e1;
		evec_t e2;
	} geom_t;

	typedef struct packed {
		logic                 valid;
		logic signed [DW-1:0] det;
		logic signed [DW-1:0] u;
		logic signed [DW-1:0] v;
		logic signed [DW-1:0] t;
	} sums_t;

	typedef struct packed {
		logic          valid;
		logic          hit;
		logic          sat;
		logic [RW-1:0] num;
		logic [NW-1:0] den;
	} div_in_t;

	function automatic pvec_t cross3(evec_t a, evec_t b);
		pvec_t r;
		r.x = PW'(a.y) * PW'(b.z) - PW'(a.z) * PW'(b.y);
		r.y = PW'(a.z) * PW'(b.x) - PW'(a.x) * PW'(b.z);
		r.z = PW'(a.x) * PW'(b.y) - PW'(a.y) * PW'(b.x);
		return r;
	endfunction

	function automatic mvec_t mul3(evec_t a, pvec_t b);
		mvec_t r;
		r.x = MW'(a.x) * MW'(b.x);
		r.y = MW'(a.y) * MW'(b.y);
		r.z = MW'(a.z) * MW'(b.z);
		return r;
	endfunction

	function automatic logic signed [DW-1:0] sum3(mvec_t m);
		return DW'(m.x) + DW'(m.y) + DW'(m.z);
	endfunction

endpackage

@@ hw/rtl/rti_front.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection: vector front end
// Four stages: origin offset, cross products, partial products, dot sums.
// ----------------------------------------------------------------------------
module rti_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           ray_valid,
	input  rti_pkg::ray_t  ray,
	input  rti_pkg::geom_t geom,
	output rti_pkg::sums_t sums
);
	import rti_pkg::*;

	logic  valid_s1, valid_s2, valid_s3, valid_s4;
	evec_t d_s1, s_s1, d_s2, s_s2;
	pvec_t p_s2, q_s2;
	mvec_t mdet_s3, mu_s3, mv_s3, mt_s3;
	logic signed [DW-1:0] det_s4, u_s4, v_s4, t_s4;
	logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;

	assign ox = CW'(ray.origin_x);
	assign oy = CW'(ray.origin_y);
	assign oz = CW'(ray.origin_z);
	assign dx = CW'(ray.dir_x);
	assign dy = CW'(ray.dir_y);
	assign dz = CW'(ray.dir_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ray_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1.x  <= EW'(ox) - geom.a.x;
			s_s1.y  <= EW'(oy) - geom.a.y;
			s_s1.z  <= EW'(oz) - geom.a.z;
			d_s1.x  <= EW'(dx);
			d_s1.y  <= EW'(dy);
			d_s1.z  <= EW'(dz);
			p_s2    <= cross3(d_s1, geom.e2);
			q_s2    <= cross3(s_s1, geom.e1);
			d_s2    <= d_s1;
			s_s2    <= s_s1;
			mdet_s3 <= mul3(geom.e1, p_s2);
			mu_s3   <= mul3(s_s2, p_s2);
			mv_s3   <= mul3(d_s2, q_s2);
			mt_s3   <= mul3(geom.e2, q_s2);
			det_s4  <= sum3(mdet_s3);
			u_s4    <= sum3(mu_s3);
			v_s4    <= sum3(mv_s3);
			t_s4    <= sum3(mt_s3);
		end
	end

	assign sums.valid = valid_s4;
	assign sums.det   = det_s4;
	assign sums.u     = u_s4;
	assign sums.v     = v_s4;
	assign sums.t     = t_s4;

endmodule

@@ hw/rtl/rti_classify.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection: hit classification
// Sign fix, tolerance scaling and the miss tests, over three stages.
// ----------------------------------------------------------------------------
module rti_classify (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [rti_pkg::MPW-1:0]   tolerance,
	input  rti_pkg::sums_t            sums,
	output rti_pkg::div_in_t          div_in
);
	import rti_pkg::*;

	logic valid_s5, valid_s6, valid_s7;
	logic signed [NW-1:0]  det_s5, u_s5, v_s5, t_s5;
	logic signed [NW-1:0]  det_s6, u_s6, v_s6, t_s6;
	logic signed [MDW-1:0] mdet_s6;
	logic                  hit_s7, sat_s7;
	logic [RW-1:0]         num_s7;
	logic [NW-1:0]         den_s7;
	logic                  neg;
	logic signed [XW-1:0]  x_det, x_u, x_v, x_t, x_md, x_tol, x_vs, x_ts;
	logic                  miss;

	assign neg = sums.det < 0;

	assign x_det = XW'(det_s6);
	assign x_u   = XW'(u_s6);
	assign x_v   = XW'(v_s6);
	assign x_t   = XW'(t_s6);
	assign x_md  = XW'(mdet_s6);
	assign x_tol = XW'($signed({1'b0, tolerance, {TOL_SHIFT{1'b0}}}));
	assign x_vs  = x_v <<< FRAC;
	assign x_ts  = x_t <<< FRAC;

	// Parallel ray, u outside the unit range, v below minus the tolerance,
	// u+v beyond one, or t too close.
	assign miss = (x_det == '0) || (x_det < x_tol)
		|| (x_u < 0) || (x_det < x_u)
		|| ((x_vs + x_md) < 0)
		|| (x_det < (x_u + x_v))
		|| (x_ts < x_md);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= sums.valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5  <= neg ? -NW'(sums.det) : NW'(sums.det);
			u_s5    <= neg ? -NW'(sums.u)   : NW'(sums.u);
			v_s5    <= neg ? -NW'(sums.v)   : NW'(sums.v);
			t_s5    <= neg ? -NW'(sums.t)   : NW'(sums.t);
			mdet_s6 <= MDW'(det_s5) * MDW'($signed({1'b0, tolerance}));
			det_s6  <= det_s5;
			u_s6    <= u_s5;
			v_s6    <= v_s5;
			t_s6    <= t_s5;
			hit_s7  <= !miss;
			sat_s7  <= x_t >= (x_det <<< FRAC);
			num_s7  <= RW'($unsigned(t_s6)) << FRAC;
			den_s7  <= $unsigned(det_s6);
		end
	end

	assign div_in.valid = valid_s7;
	assign div_in.hit   = hit_s7;
	assign div_in.sat   = sat_s7;
	assign div_in.num   = num_s7;
	assign div_in.den   = den_s7;

endmodule

@@ hw/rtl/rti_divider.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection: pipelined divider
// Restoring division, one quotient bit per stage, with saturation and miss.
// ----------------------------------------------------------------------------
module rti_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  rti_pkg::div_in_t div_in,
	output logic             result_valid,
	output rti_pkg::result_t result
);
	import rti_pkg::*;

	// Entry k holds the beat once quotient bit QBITS-1-k has been decided.
	logic              valid_sd [QBITS];
	logic              hit_sd   [QBITS];
	logic              sat_sd   [QBITS];
	logic [RW-1:0]     rem_sd   [QBITS];
	logic [NW-1:0]     den_sd   [QBITS];
	logic [QBITS-1:0]  quo_sd   [QBITS];

	// What each stage works on: the incoming beat for the first stage,
	// the previous stage for the others.
	logic              valid_in [QBITS];
	logic              hit_in   [QBITS];
	logic              sat_in   [QBITS];
	logic [RW-1:0]     rem_in   [QBITS];
	logic [NW-1:0]     den_in   [QBITS];
	logic [QBITS-1:0]  quo_in   [QBITS];
	logic [QW-1:0]     shifted  [QBITS];
	logic              take     [QBITS];

	always_comb begin
		valid_in[0] = div_in.valid;
		hit_in[0]   = div_in.hit;
		sat_in[0]   = div_in.sat;
		rem_in[0]   = div_in.num;
		den_in[0]   = div_in.den;
		quo_in[0]   = '0;
		for (int k = 1; k < QBITS; k++) begin
			valid_in[k] = valid_sd[k-1];
			hit_in[k]   = hit_sd[k-1];
			sat_in[k]   = sat_sd[k-1];
			rem_in[k]   = rem_sd[k-1];
			den_in[k]   = den_sd[k-1];
			quo_in[k]   = quo_sd[k-1];
		end
		for (int k = 0; k < QBITS; k++) begin
			shifted[k] = QW'(den_in[k]) << (QBITS - 1 - k);
			take[k]    = QW'(rem_in[k]) >= shifted[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QBITS; k++) begin
				valid_sd[k] <= 1'b0;
			end
		end else if (en) begin
			for (int k = 0; k < QBITS; k++) begin
				valid_sd[k] <= valid_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QBITS; k++) begin
				hit_sd[k] <= hit_in[k];
				sat_sd[k] <= sat_in[k];
				den_sd[k] <= den_in[k];
				rem_sd[k] <= take[k] ? RW'(QW'(rem_in[k]) - shifted[k]) : rem_in[k];
				quo_sd[k] <= quo_in[k] | (QBITS'(take[k]) << (QBITS - 1 - k));
			end
		end
	end

	assign result_valid    = valid_sd[QBITS-1];
	assign result.hit      = hit_sd[QBITS-1];
	assign result.distance = !hit_sd[QBITS-1] ? '0
		: (sat_sd[QBITS-1] ? '1 : quo_sd[QBITS-1]);

endmodule

@@ hw/rtl/ray_triangle_intersect_top.sv @@
// Pipeline: an accepted ray beat passes 4 vector stages, 3 classification
// stages and 32 divider stages before its result beat.
// Throughput: one ray per cycle; the whole pipeline holds while a result is stalled.
// Reset: arst_n clears all valid bits at once; the vertices reset to zero and
// the tolerance to 66. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// Ray/triangle intersection top level
// Moller-Trumbore test of a stream of rays against one configured triangle,
// returning hit and distance in unsigned Q16.16.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_top_defines.svh"

module ray_triangle_intersect_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ray_valid,
	output logic                            ray_stall,
	input  rti_pkg::ray_t                   ray,
	output logic                            result_valid,
	input  logic                            result_stall,
	output rti_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rti_pkg::IDX_W-1:0]       cfg_index,
	input  logic [rti_pkg::VTX_W-1:0]       cfg_data
);
	import rti_pkg::*;

	// Configuration registers, which the user must change only while the pipeline is
	// empty (the block does not enforce it); the derived triangle edges feed every stage directly.
	logic [VTX_W-1:0] vertex_a_q, vertex_b_q, vertex_c_q;
	logic [MPW-1:0]   tolerance_q;

	logic [3*CW-1:0]  va, vb, vc;
	geom_t            geom;
	sums_t            sums;
	div_in_t          div_in;
	logic             en;

	// The write port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_a_q  <= '0;
			vertex_b_q  <= '0;
			vertex_c_q  <= '0;
			tolerance_q <= MPW'(66);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VERTEX_A:  vertex_a_q  <= cfg_data;
				REG_VERTEX_B:  vertex_b_q  <= cfg_data;
				REG_VERTEX_C:  vertex_c_q  <= cfg_data;
				REG_TOLERANCE: tolerance_q <= cfg_data[MPW-1:0];
				default: ;
			endcase
		end
	end

	// Each vertex packs x, y, z as signed Q8.8 slots with x in the low bits.
	assign va = (3*CW)'(vertex_a_q);
	assign vb = (3*CW)'(vertex_b_q);
	assign vc = (3*CW)'(vertex_c_q);

	always_comb begin
		geom.a.x  = EW'($signed(va[0*CW +: CW]));
		geom.a.y  = EW'($signed(va[1*CW +: CW]));
		geom.a.z  = EW'($signed(va[2*CW +: CW]));
		geom.e1.x = EW'($signed(vb[0*CW +: CW])) - geom.a.x;
		geom.e1.y = EW'($signed(vb[1*CW +: CW])) - geom.a.y;
		geom.e1.z = EW'($signed(vb[2*CW +: CW])) - geom.a.z;
		geom.e2.x = EW'($signed(vc[0*CW +: CW])) - geom.a.x;
		geom.e2.y = EW'($signed(vc[1*CW +: CW])) - geom.a.y;
		geom.e2.z = EW'($signed(vc[2*CW +: CW])) - geom.a.z;
	end

	// The pipeline advances as a whole unless a finished result is held
	// back; bubbles move on, so a new ray is taken whenever the output flows.
	assign en        = !(result_valid && result_stall);
	assign ray_stall = !en;

	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ray_valid (ray_valid),
		.ray       (ray),
		.geom      (geom),
		.sums      (sums)
	);

	rti_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tolerance (tolerance_q),
		.sums      (sums),
		.div_in    (div_in)
	);

	rti_divider u_divider (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.div_in       (div_in),
		.result_valid (result_valid),
		.result       (result)
	);

	// A miss always reports a zero distance.
	`RTI_ASSERT_IMP(a_miss_zero, result_valid && !result.hit, result.distance == '0, "miss with non-zero distance")
	// While the pipeline is held, the waiting result does not change.
	`RTI_ASSERT_NXT(a_hold_result, !en, $stable(result) && $stable(result_valid), "held result changed")
	// A ray is never taken while a finished result is held back.
	`RTI_ASSERT_IMP(a_no_take_on_hold, ray_valid && !ray_stall, !(result_valid && result_stall), "ray taken while output held")

endmodule

@@ tb/sv/ray_triangle_intersect_checker.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection checker
// Watches the ray, result and register channels, predicts each result beat
// with exact integer arithmetic and compares it field by field.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ray_valid,
	input  logic                      ray_stall,
	input  rti_pkg::ray_t             ray,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  rti_pkg::result_t          result,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [rti_pkg::IDX_W-1:0] cfg_index,
	input  logic [rti_pkg::VTX_W-1:0] cfg_data,
	output int                        errors,
	output int                        pending,
	output int                        hits
);
	import rti_pkg::*;

	logic [VTX_W-1:0] vtx_a, vtx_b, vtx_c;
	logic [15:0]      min_prox;
	result_t          expected_results[$];

	function automatic longint slot(logic [VTX_W-1:0] v, int k);
		return longint'($signed(v[16*k +: 16]));
	endfunction

	function automatic result_t predict_hit(ray_t r);
		longint o[3], d[3], va[3], vb[3], vc[3], e1[3], e2[3], s[3], p[3], q[3];
		logic signed [127:0] det, un, vn, tn, mdet, tol, mpw, num;
		result_t res;
		res = '0;
		o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
		d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
		for (int k = 0; k < 3; k++) begin
			va[k] = slot(vtx_a, k);
			vb[k] = slot(vtx_b, k);
			vc[k] = slot(vtx_c, k);
			e1[k] = vb[k] - va[k];
			e2[k] = vc[k] - va[k];
			s[k]  = o[k] - va[k];
		end
		p[0] = d[1] * e2[2] - d[2] * e2[1];
		p[1] = d[2] * e2[0] - d[0] * e2[2];
		p[2] = d[0] * e2[1] - d[1] * e2[0];
		q[0] = s[1] * e1[2] - s[2] * e1[1];
		q[1] = s[2] * e1[0] - s[0] * e1[2];
		q[2] = s[0] * e1[1] - s[1] * e1[0];
		det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
		un  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
		vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
		tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
		if (det < 0) begin
			det = -det; un = -un; vn = -vn; tn = -tn;
		end
		mpw  = min_prox;
		tol  = mpw <<< 8;
		mdet = det * mpw;
		if (det == 0 || det < tol) return res;
		if (un < 0 || un > det) return res;
		if ((vn <<< 16) + mdet < 0) return res;
		if (un + vn > det) return res;
		if ((tn <<< 16) < mdet) return res;
		num = tn <<< 16;
		res.hit = 1'b1;
		if (num >= (det <<< 32))
			res.distance = 32'hFFFF_FFFF;
		else
			res.distance = 32'(num / det);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			vtx_a    <= '0;
			vtx_b    <= '0;
			vtx_c    <= '0;
			min_prox <= 16'd66;
			errors   <= 0;
			hits     <= 0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VERTEX_A:  vtx_a <= cfg_data;
					REG_VERTEX_B:  vtx_b <= cfg_data;
					REG_VERTEX_C:  vtx_c <= cfg_data;
					REG_TOLERANCE: min_prox <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat hit=%0b distance=%h",
						$time, result.hit, result.distance);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.hit)
						hits <= hits + 1;
					if (result.hit !== want.hit) begin
						$display("%0t: hit expected %0b actual %0b",
							$time, want.hit, result.hit);
						errors <= errors + 1;
					end else if (result.distance !== want.distance) begin
						$display("%0t: distance expected %h actual %h",
							$time, want.distance, result.distance);
						errors <= errors + 1;
					end
				end
			end
			if (ray_valid && !ray_stall)
				expected_results.push_back(predict_hit(ray));
		end
	end

	assign pending = expected_results.size();

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Ray/triangle intersection testbench
// Streams directed and random rays against a series of triangles and
// tolerances, with random idling on both channels; the checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import rti_pkg::*;

	// An index that decodes to no register; writes to it must be ignored.
	localparam logic [IDX_W-1:0] REG_UNUSED = 8'd7;
	localparam int DRAIN_CYCLES = 50;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             ray_valid = 1'b0;
	logic             ray_stall;
	ray_t             ray = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [VTX_W-1:0] cfg_data = '0;
	int               errors, pending, hits;
	int               send_idle, recv_idle, rays_sent;
	int               ax, ay, az, bx, by, bz, cx, cy, cz;

	always #5 clk = ~clk;

	ray_triangle_intersect_top uut (.*);

	ray_triangle_intersect_checker checker_i (.*);

	// The receiver stalls at random; the level changes per phase.
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < recv_idle);

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

	// One ray beat. Stall is sampled on the falling edge, where it has settled
	// for the coming rising edge, so acceptance never races the block.
	task automatic send_ray(input ray_t r);
		logic st;
		while ($urandom_range(99) < send_idle) begin
			ray_valid <= 1'b0;
			@(posedge clk);
		end
		ray_valid <= 1'b1;
		ray       <= r;
		do begin
			@(negedge clk);
			st = ray_stall;
			@(posedge clk);
		end while (st);
		rays_sent++;
	endtask

	// Register writes happen only with the pipeline empty. The task waits for a rising
	// edge first so that the last accepted ray is already counted as pending.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VTX_W-1:0] val);
		logic rd;
		ray_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			rd = cfg_ready;
			@(posedge clk);
		end while (!rd);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VTX_W-1:0] pack_vtx(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic int coord();
		return int'($urandom_range(4000)) - 2000;
	endfunction

	task automatic set_triangle();
		ax = coord(); ay = coord(); az = coord();
		bx = coord(); by = coord(); bz = coord();
		cx = coord(); cy = coord(); cz = coord();
		write_reg(REG_VERTEX_A, pack_vtx(ax, ay, az));
		write_reg(REG_VERTEX_B, pack_vtx(bx, by, bz));
		write_reg(REG_VERTEX_C, pack_vtx(cx, cy, cz));
	endtask

	// A ray from a random origin towards a point given by barycentric weights
	// (in 256ths), optionally shortened so that t grows.
	function automatic ray_t aimed_ray(int u, int v, int div);
		ray_t r;
		int tx, ty, tz, ox, oy, oz;
		tx = ax + (u * (bx - ax) + v * (cx - ax)) / 256;
		ty = ay + (u * (by - ay) + v * (cy - ay)) / 256;
		tz = az + (u * (bz - az) + v * (cz - az)) / 256;
		ox = coord(); oy = coord(); oz = coord();
		r.origin_x = 16'(ox); r.origin_y = 16'(oy); r.origin_z = 16'(oz);
		r.dir_x = 16'((tx - ox) / div);
		r.dir_y = 16'((ty - oy) / div);
		r.dir_z = 16'((tz - oz) / div);
		return r;
	endfunction

	function automatic ray_t noise_ray();
		return ray_t'({$urandom(), $urandom(), $urandom()});
	endfunction

	task automatic random_rays(input int n);
		int u, v, sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(9);
			if (sel < 2) begin
				send_ray(noise_ray());
			end else begin
				// Weights reach a little past each edge so both sides of every
				// bound on u and v are exercised.
				u = int'($urandom_range(300)) - 20;
				v = int'($urandom_range(300)) - 20;
				send_ray(aimed_ray(u, v, (sel < 5) ? 1 : int'($urandom_range(8)) + 1));
			end
		end
	endtask

	initial begin
		ray_t r;
		send_idle = 0;
		recv_idle = 0;
		rays_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset triangle is degenerate: every ray misses on a zero determinant.
		r = '0;
		send_ray(r);
		r = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
		send_ray(r);
		send_ray(~r);

		// A unit right triangle in the z = 0 plane, rays along -z.
		ax = 0;   ay = 0;   az = 0;
		bx = 256; by = 0;   bz = 0;
		cx = 0;   cy = 256; cz = 0;
		write_reg(REG_VERTEX_A, pack_vtx(ax, ay, az));
		write_reg(REG_VERTEX_B, pack_vtx(bx, by, bz));
		write_reg(REG_VERTEX_C, pack_vtx(cx, cy, cz));
		// Straight hit, t of one.
		send_ray({16'sd64, 16'sd64, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		// Parallel to the plane.
		send_ray({16'sd64, 16'sd64, 16'sd256, 16'sd256, 16'sd0, 16'sd0});
		// Negative u, then u above one.
		send_ray({-16'sd10, 16'sd64, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		send_ray({16'sd300, 16'sd0, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		// Negative v, and u plus v above one.
		send_ray({16'sd64, -16'sd10, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		send_ray({16'sd200, 16'sd200, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		// Triangle behind the origin, then in the plane itself.
		send_ray({16'sd64, 16'sd64, -16'sd256, 16'sd0, 16'sd0, -16'sd256});
		send_ray({16'sd64, 16'sd64, 16'sd0, 16'sd0, 16'sd0, -16'sd256});
		// Tiny direction from far away: a large distance, still below saturation.
		send_ray({16'sd64, 16'sd64, 16'sh7FFF, 16'sd0, 16'sd0, -16'sd1});
		// Tolerance extremes: none at all, then the largest.
		write_reg(REG_TOLERANCE, 48'd0);
		send_ray({16'sd64, 16'sd64, 16'sd0, 16'sd0, 16'sd0, -16'sd256});
		send_ray({16'sd64, -16'sd1, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		write_reg(REG_TOLERANCE, 48'hFFFF_FFFF_FFFF);
		send_ray({16'sd64, -16'sd1, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		send_ray({16'sd64, 16'sd64, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		// Writes to an undecoded index leave every register alone.
		write_reg(REG_UNUSED, 48'h1234_5678_9ABC);
		send_ray({16'sd64, 16'sd64, 16'sd256, 16'sd0, 16'sd0, -16'sd256});
		// Full-width vertex values, upper slots included.
		write_reg(REG_VERTEX_A, 48'({$urandom(), $urandom()}));
		write_reg(REG_VERTEX_B, 48'({$urandom(), $urandom()}));
		write_reg(REG_VERTEX_C, 48'({$urandom(), $urandom()}));
		for (int i = 0; i < 4; i++)
			send_ray(noise_ray());

		// Three idling phases, each over a few triangles and tolerances,
		// the reset value and both extremes among them.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 38 : (ph == 1) ? 45 : 0;
			recv_idle = (ph == 0) ? 45 : (ph == 1) ? 38 : 0;
			for (int tri_n = 0; tri_n < 4; tri_n++) begin
				set_triangle();
				case (tri_n)
					0: write_reg(REG_TOLERANCE, 48'd66);
					1: write_reg(REG_TOLERANCE, 48'd0);
					2: write_reg(REG_TOLERANCE, 48'hFFFF);
					default: write_reg(REG_TOLERANCE, 48'($urandom_range(65535)));
				endcase
				random_rays(80);
			end
		end

		ray_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d rays over degenerate, unit and random triangles,", rays_sent);
		$display("with %0d hits, four tolerance settings and three idling mixes.", hits);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
